// File: hdl/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int WORD_W     = 32;
  localparam int OPCODE_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int DEPTH_DEF  = 16;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] popped_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins_front;
    logic              ins_back;
    logic              rem_front;
    logic              rem_back;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: hdl/bdeq_cell.sv
// ----------------------------------------------------------------------------
// bdeq_cell
// One storage cell of the deque chain: a word and its occupied flag.
// ----------------------------------------------------------------------------
module bdeq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bdeq_pkg::cell_cmd_t              cmd,
  input  logic [bdeq_pkg::WORD_W-1:0]      left_data,
  input  logic                             left_valid,
  input  logic [bdeq_pkg::WORD_W-1:0]      right_data,
  input  logic                             right_valid,
  output logic [bdeq_pkg::WORD_W-1:0]      data_q,
  output logic                             valid_q
);

  logic [bdeq_pkg::WORD_W-1:0] data_r;
  logic [bdeq_pkg::WORD_W-1:0] data_nxt;
  logic                        valid_r;
  logic                        valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    priority if (cmd.ins_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (cmd.ins_back) begin
      if (!valid_r && left_valid) begin
        data_nxt  = cmd.value;
        valid_nxt = 1'b1;
      end
    end else if (cmd.rem_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (cmd.rem_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_q  = data_r;
  assign valid_q = valid_r;

endmodule

// File: hdl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Deque of signed 32-bit words held in a chain of storage cells.
// ----------------------------------------------------------------------------
// Each item on the in_ channel is one operation: push front, push back,
// pop front, pop back or query. Every item yields exactly one result item on
// the out_ channel with a status, the popped word, the entry count, an empty
// flag and the front and back words after the operation.
// The front word always sits in the first cell. A push at the front or a
// pop at the front shifts every cell of the chain by one place together; a
// back operation touches only the cell at the edge of the occupied region.
// The chain is updated at the accepting edge, the result is formed in the
// following cycle (S_BUILD) and registered as out_valid rises in S_SEND.
// The back word comes from a one-hot select across all cells, which is why
// the result is formed in a cycle of its own.
// One item is in flight at a time: in_ready stays low until the result has
// been taken, so no new item is taken while one is in S_BUILD or S_SEND.
// A stalled receiver holds the result and blocks input for each stalled cycle.
// After reset the deque is empty and in_ready is high.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bdeq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bdeq_pkg::out_t  out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > bdeq_pkg::COUNT_W) ? CW : bdeq_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BUILD = 2'd1;
  localparam logic [1:0] S_SEND  = 2'd2;

  logic [1:0]                     state_r;
  logic [1:0]                     state_nxt;
  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  count_nxt;
  logic [bdeq_pkg::STATUS_W-1:0]  status_r;
  logic [bdeq_pkg::STATUS_W-1:0]  status_nxt;
  logic [bdeq_pkg::WORD_W-1:0]    popped_r;
  logic [bdeq_pkg::WORD_W-1:0]    popped_nxt;
  bdeq_pkg::out_t                 out_r;
  bdeq_pkg::out_t                 out_nxt;
  bdeq_pkg::cell_cmd_t            cmd;

  logic [bdeq_pkg::WORD_W-1:0]    cell_data [DEPTH];
  logic [DEPTH-1:0]               cell_valid;
  logic [DEPTH-1:0]               is_last;
  logic [bdeq_pkg::WORD_W-1:0]    back_word;
  logic                           accept;
  logic                           full;
  logic                           empty;
  logic [EW-1:0]                  count_ext;

  assign accept = in_valid && in_ready;
  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [bdeq_pkg::WORD_W-1:0] l_data;
      logic                        l_valid;
      logic [bdeq_pkg::WORD_W-1:0] r_data;
      logic                        r_valid;
      if (gi == 0) begin : g_first
        assign l_data  = cmd.value;
        assign l_valid = 1'b1;
      end else begin : g_inner_l
        assign l_data  = cell_data[gi-1];
        assign l_valid = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner_r
        assign r_data  = cell_data[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      assign is_last[gi] = cell_valid[gi] && !r_valid;
      bdeq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data_q      (cell_data[gi]),
        .valid_q     (cell_valid[gi])
      );
    end
  endgenerate

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (is_last[i] ? cell_data[i] : '0);
    end
  end

  always_comb begin
    cmd.ins_front = 1'b0;
    cmd.ins_back  = 1'b0;
    cmd.rem_front = 1'b0;
    cmd.rem_back  = 1'b0;
    cmd.value     = in_data.push_value;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    count_nxt     = count_r;
    if (accept) begin
      status_nxt = bdeq_pkg::ST_OK;
      popped_nxt = '0;
      unique case (in_data.opcode)
        bdeq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = bdeq_pkg::ST_FULL;
          end else begin
            cmd.ins_front = 1'b1;
            count_nxt     = count_r + CW'(1);
          end
        end
        bdeq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = bdeq_pkg::ST_FULL;
          end else begin
            cmd.ins_back = 1'b1;
            count_nxt    = count_r + CW'(1);
          end
        end
        bdeq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = bdeq_pkg::ST_EMPTY;
          end else begin
            cmd.rem_front = 1'b1;
            popped_nxt    = cell_data[0];
            count_nxt     = count_r - CW'(1);
          end
        end
        bdeq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = bdeq_pkg::ST_EMPTY;
          end else begin
            cmd.rem_back = 1'b1;
            popped_nxt   = back_word;
            count_nxt    = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count_ext = EW'(count_r);

  always_comb begin
    out_nxt              = out_r;
    state_nxt            = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        out_nxt.status       = status_r;
        out_nxt.popped_value = popped_r;
        out_nxt.entry_count  = count_ext[bdeq_pkg::COUNT_W-1:0];
        out_nxt.is_empty     = empty;
        out_nxt.front_value  = empty ? '0 : cell_data[0];
        out_nxt.back_value   = empty ? '0 : back_word;
        state_nxt            = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);
  assign out_data  = out_r;

endmodule

// File: hdl/bdeq_checker.sv
// ----------------------------------------------------------------------------
// bdeq_checker
// Port-level checks for the bounded double-ended queue.
// ----------------------------------------------------------------------------
module bdeq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bdeq_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("A stalled result item changed or was dropped.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second item was taken while one was still in flight.");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.entry_count == '0 && out_data.front_value == '0 &&
      out_data.back_value == '0)
    else $error("An empty deque reported a count or a stored word.");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bdeq_pkg::ST_EMPTY |->
      out_data.is_empty && out_data.popped_value == '0)
    else $error("A failed pop reported a word or a non-empty deque.");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bdeq_pkg::ST_FULL |->
      !out_data.is_empty && out_data.popped_value == '0)
    else $error("A dropped push reported a word or an empty deque.");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);
